// ===== rtl/core/mam_pkg.sv =====
`timescale 1ns / 1ps

package mam_pkg;

  // Matrix geometry
  localparam int MATRIX_DIM = 4;
  localparam int DIM_W      = $clog2(MATRIX_DIM);
  localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
  localparam int BANKS      = 2;
  localparam int ADDR_W     = $clog2(BANKS * CELLS);

  // Field widths
  localparam int ELEM_W = 16;
  localparam int MUL_W  = 2 * ELEM_W;
  localparam int SUM_W  = 17;
  localparam int PROD_W = 34;
  localparam int DIAG_W = 19;
  localparam int IDX_W  = 4;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Element store write from the front
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
  } mem_wr_t;

  // One loaded matrix pair ready for the back
  typedef struct packed {
    logic                     bank;
    logic signed [DIAG_W-1:0] diag;
  } job_t;

  // Bank handed back to the front once its last result is out
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

// ===== rtl/core/mam_ram.sv =====
`timescale 1ns / 1ps

module mam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while disabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mam_front.sv =====
`timescale 1ns / 1ps

module mam_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mam_pkg::ELEM_W-1:0]      a_element,
  input  logic [mam_pkg::ELEM_W-1:0]      b_element,
  output mam_pkg::mem_wr_t                mem_wr,
  output logic                            q_push,
  output mam_pkg::job_t                   q_job,
  input  logic                            q_full,
  input  mam_pkg::rel_t                   release_bank
);

  import mam_pkg::*;

  logic [DIM_W-1:0]         row;
  logic [DIM_W-1:0]         col;
  logic                     wbank;
  logic [BANKS-1:0]         busy;
  logic signed [DIAG_W-1:0] diag;

  logic                     accept;
  logic                     final_cell;
  logic                     on_main;
  logic                     on_anti;
  logic signed [DIAG_W-1:0] a_ext;
  logic signed [DIAG_W-1:0] diag_next;

  assign final_cell = (row == DIM_W'(MATRIX_DIM - 1)) && (col == DIM_W'(MATRIX_DIM - 1));
  assign in_ready   = !busy[wbank] && !(final_cell && q_full);
  assign accept     = in_valid && in_ready;

  // Classify the element against both diagonals
  assign on_main   = (row == col);
  assign on_anti   = ((int'(row) + int'(col)) == (MATRIX_DIM - 1));
  assign a_ext     = DIAG_W'($signed(a_element));
  assign diag_next = diag + (on_main ? a_ext : '0) + (on_anti ? a_ext : '0);

  // Store the element pair into the current bank
  always_comb begin
    mem_wr.en   = accept;
    mem_wr.addr = ADDR_W'(int'(wbank) * CELLS + int'(row) * MATRIX_DIM + int'(col));
    mem_wr.a    = a_element;
    mem_wr.b    = b_element;
  end

  // Hand a full pair to the back
  assign q_push    = accept && final_cell;
  assign q_job.bank = wbank;
  assign q_job.diag = diag_next;

  // Advance the load position and bank ownership
  always_ff @(posedge clk) begin
    if (rst) begin
      row   <= '0;
      col   <= '0;
      wbank <= 1'b0;
      busy  <= '0;
      diag  <= '0;
    end else begin
      if (release_bank.valid) begin
        busy[release_bank.bank] <= 1'b0;
      end
      if (accept) begin
        if (final_cell) begin
          row         <= '0;
          col         <= '0;
          diag        <= '0;
          busy[wbank] <= 1'b1;
          wbank       <= ~wbank;
        end else begin
          diag <= diag_next;
          if (col == DIM_W'(MATRIX_DIM - 1)) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/mam_queue.sv =====
`timescale 1ns / 1ps

module mam_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mam_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output mam_pkg::job_t pop_job
);

  import mam_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = slots[rd_ptr];

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(push && !full) - (QPTR_W + 1)'(pop && not_empty);
    end
  end

endmodule

// ===== rtl/core/mam_back.sv =====
`timescale 1ns / 1ps

module mam_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  mam_pkg::job_t                     q_job,
  output logic                              q_pop,
  output logic                              rd_en,
  output logic [mam_pkg::ADDR_W-1:0]        rd_addr_a,
  output logic [mam_pkg::ADDR_W-1:0]        rd_addr_b,
  input  logic [mam_pkg::ELEM_W-1:0]        rd_data_a,
  input  logic [mam_pkg::ELEM_W-1:0]        rd_data_b,
  output mam_pkg::rel_t                     release_bank,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mam_pkg::SUM_W-1:0]  sum_element,
  output logic signed [mam_pkg::PROD_W-1:0] product_element,
  output logic signed [mam_pkg::DIAG_W-1:0] diagonal_sum,
  output logic [mam_pkg::IDX_W-1:0]         element_index,
  output logic                              last
);

  import mam_pkg::*;

  localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MATRIX_DIM - 1);

  // Issue stage: current job and position
  logic                     active;
  logic                     job_bank;
  logic signed [DIAG_W-1:0] job_diag;
  logic [DIM_W-1:0]         r;
  logic [DIM_W-1:0]         c;
  logic [DIM_W-1:0]         k;

  // Read stage sideband, aligned with the store read data
  logic                     s1_valid;
  logic                     s1_bank;
  logic signed [DIAG_W-1:0] s1_diag;
  logic [DIM_W-1:0]         s1_r;
  logic [DIM_W-1:0]         s1_c;
  logic [DIM_W-1:0]         s1_k;

  // Multiply stage
  logic                     s2_valid;
  logic                     s2_bank;
  logic signed [DIAG_W-1:0] s2_diag;
  logic [DIM_W-1:0]         s2_r;
  logic [DIM_W-1:0]         s2_c;
  logic [DIM_W-1:0]         s2_k;
  logic signed [MUL_W-1:0]  s2_prod;
  logic signed [SUM_W-1:0]  s2_sum_part;

  // Accumulators
  logic signed [PROD_W-1:0] acc;
  logic signed [SUM_W-1:0]  sacc;

  logic                     stall;
  logic                     finish;
  logic signed [SUM_W-1:0]  a_sum_ext;
  logic signed [SUM_W-1:0]  b_sum_ext;
  logic signed [SUM_W-1:0]  sum_part;
  logic signed [PROD_W-1:0] acc_total;
  logic signed [SUM_W-1:0]  sacc_total;

  // Hold the whole pipeline while a finished result has nowhere to go
  assign finish = s2_valid && (s2_k == DIM_LAST);
  assign stall  = finish && out_valid && !out_ready;
  assign rd_en  = !stall;
  assign q_pop  = !active && q_valid;

  // Row of A against column of B, one term per cycle
  assign rd_addr_a = ADDR_W'(int'(job_bank) * CELLS + int'(r) * MATRIX_DIM + int'(k));
  assign rd_addr_b = ADDR_W'(int'(job_bank) * CELLS + int'(k) * MATRIX_DIM + int'(c));

  // Pick out A and B at the result position as they pass
  assign a_sum_ext = SUM_W'($signed(rd_data_a));
  assign b_sum_ext = SUM_W'($signed(rd_data_b));
  assign sum_part  = ((s1_k == s1_c) ? a_sum_ext : '0) + ((s1_k == s1_r) ? b_sum_ext : '0);

  assign acc_total  = ((s2_k == '0) ? '0 : acc) + PROD_W'(s2_prod);
  assign sacc_total = ((s2_k == '0) ? '0 : sacc) + s2_sum_part;

  // Free the bank once its last result is captured
  assign release_bank.valid = finish && !stall && (s2_r == DIM_LAST) && (s2_c == DIM_LAST);
  assign release_bank.bank  = s2_bank;

  // Issue counters
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      r      <= '0;
      c      <= '0;
      k      <= '0;
    end else if (q_pop) begin
      active   <= 1'b1;
      job_bank <= q_job.bank;
      job_diag <= q_job.diag;
      r        <= '0;
      c        <= '0;
      k        <= '0;
    end else if (active && !stall) begin
      if (k == DIM_LAST) begin
        k <= '0;
        if (c == DIM_LAST) begin
          c <= '0;
          if (r == DIM_LAST) begin
            r      <= '0;
            active <= 1'b0;
          end else begin
            r <= r + 1'b1;
          end
        end else begin
          c <= c + 1'b1;
        end
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  // Advance the read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= active && !q_pop;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_bank     <= job_bank;
      s1_diag     <= job_diag;
      s1_r        <= r;
      s1_c        <= c;
      s1_k        <= k;
      s2_bank     <= s1_bank;
      s2_diag     <= s1_diag;
      s2_r        <= s1_r;
      s2_c        <= s1_c;
      s2_k        <= s1_k;
      s2_prod     <= $signed(rd_data_a) * $signed(rd_data_b);
      s2_sum_part <= sum_part;
    end
  end

  // Accumulate partial terms
  always_ff @(posedge clk) begin
    if (s2_valid && !finish) begin
      acc  <= acc_total;
      sacc <= sacc_total;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && !stall) begin
      sum_element     <= sacc_total;
      product_element <= acc_total;
      diagonal_sum    <= s2_diag;
      element_index   <= IDX_W'(int'(s2_r) * MATRIX_DIM + int'(s2_c));
      last            <= (s2_r == DIM_LAST) && (s2_c == DIM_LAST);
    end
  end

endmodule

// ===== rtl/core/matrix_add_multiply_4x4_unit.sv =====
`timescale 1ns / 1ps

// Square matrix add / multiply / diagonal-sum unit.
// Input channel (in_valid/in_ready): one item carries a_element and b_element,
// one element of A and of B, in row-major order. The item that completes the
// matrices closes the load; earlier items produce no results.
// Output channel (out_valid/out_ready): per loaded pair, one result per element
// in row-major order with A+B, the exact A*B dot product, the sum of A's main
// and anti-diagonal, the element index and last on the final element.
// Throughput: loading accepts one item per cycle while in_ready is high. The
// back end does one multiply-accumulate per cycle unless stalled, set by the
// single read port of each element store. Two store banks let the next pair
// load while the previous one is computed.
// Stalls: when out_ready is low the result is held, and the compute pipeline
// freezes once the next result is ready to leave; once both banks are taken,
// in_ready drops until one frees up.
// Reset: synchronous and active high; clears the load position, bank
// ownership, the job queue and the output valid. No clearing pass is needed.
module matrix_add_multiply_4x4_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mam_pkg::ELEM_W-1:0]        a_element,
  input  logic [mam_pkg::ELEM_W-1:0]        b_element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mam_pkg::SUM_W-1:0]  sum_element,
  output logic signed [mam_pkg::PROD_W-1:0] product_element,
  output logic signed [mam_pkg::DIAG_W-1:0] diagonal_sum,
  output logic [mam_pkg::IDX_W-1:0]         element_index,
  output logic                              last
);

  import mam_pkg::*;

  mem_wr_t           mem_wr;
  logic              q_push;
  job_t              q_push_job;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;
  job_t              q_pop_job;
  rel_t              release_bank;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [ELEM_W-1:0] rd_data_a;
  logic [ELEM_W-1:0] rd_data_b;

  // Accept and classify items
  mam_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .a_element    (a_element),
    .b_element    (b_element),
    .mem_wr       (mem_wr),
    .q_push       (q_push),
    .q_job        (q_push_job),
    .q_full       (q_full),
    .release_bank (release_bank)
  );

  // Element stores, two banks each
  mam_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (BANKS * CELLS)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.a),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  mam_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (BANKS * CELLS)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.b),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  // Jobs waiting for the back end
  mam_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (q_pop_job)
  );

  // Compute and deliver results
  mam_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_not_empty),
    .q_job           (q_pop_job),
    .q_pop           (q_pop),
    .rd_en           (rd_en),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .rd_data_a       (rd_data_a),
    .rd_data_b       (rd_data_b),
    .release_bank    (release_bank),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sum_element     (sum_element),
    .product_element (product_element),
    .diagonal_sum    (diagonal_sum),
    .element_index   (element_index),
    .last            (last)
  );

endmodule
